[hw/rtl/cfa_pkg.sv]
`default_nettype none

package cfa_pkg;

    localparam int LEN_W = 28;
    localparam int SUM_W = 32;
    localparam int CODE_W = 4;

    localparam logic [CODE_W-1:0] OP_M  = 4'd0;
    localparam logic [CODE_W-1:0] OP_I  = 4'd1;
    localparam logic [CODE_W-1:0] OP_D  = 4'd2;
    localparam logic [CODE_W-1:0] OP_N  = 4'd3;
    localparam logic [CODE_W-1:0] OP_S  = 4'd4;
    localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
    localparam logic [CODE_W-1:0] OP_X  = 4'd8;

    typedef struct packed {
        logic [SUM_W-1:0] query_sum;
        logic [SUM_W-1:0] reference_sum;
        logic [SUM_W-1:0] total_sum;
        logic [SUM_W-1:0] leading_clip_sum;
        logic [SUM_W-1:0] trailing_clip_sum;
        logic             core_seen;
        logic             form_ok;
    } acc_t;

    localparam acc_t ACC_RESET = '{
        query_sum:         '0,
        reference_sum:     '0,
        total_sum:         '0,
        leading_clip_sum:  '0,
        trailing_clip_sum: '0,
        core_seen:         1'b0,
        form_ok:           1'b1
    };

    function automatic logic eats_query(input logic [CODE_W-1:0] code);
        return (code == OP_M) || (code == OP_I) || (code == OP_S) ||
               (code == OP_EQ) || (code == OP_X);
    endfunction

    function automatic logic eats_reference(input logic [CODE_W-1:0] code);
        return (code == OP_M) || (code == OP_D) || (code == OP_N) ||
               (code == OP_EQ) || (code == OP_X);
    endfunction

    function automatic logic is_core(input logic [CODE_W-1:0] code);
        return (code == OP_M) || (code == OP_I) || (code == OP_D) ||
               (code == OP_EQ) || (code == OP_X);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cigar_footprint_accumulator_unit.sv]
// Output: the last operation passes the input register, then its result lands in the output register.
// Throughput: one operation per cycle; the input stalls only while a finished
// result waits in the output register and the input register already holds the next last item.
// Reset (aresetn low, synchronous): both pipeline registers empty, all running sums zero,
// core-seen flag clear, well-formed flag set.
`default_nettype none

module cigar_footprint_accumulator_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [cfa_pkg::LEN_W-1:0]   s_op_length,
    input  wire logic [cfa_pkg::CODE_W-1:0]  s_op_code,
    input  wire logic                        s_last,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [cfa_pkg::SUM_W-1:0]        m_query_length,
    output logic [cfa_pkg::SUM_W-1:0]        m_reference_length,
    output logic [cfa_pkg::SUM_W-1:0]        m_total_length,
    output logic [cfa_pkg::SUM_W-1:0]        m_leading_clip,
    output logic [cfa_pkg::SUM_W-1:0]        m_trailing_clip,
    output logic                             m_well_formed
);

    logic                        in_valid_reg;
    logic [cfa_pkg::LEN_W-1:0]   in_length_reg;
    logic [cfa_pkg::CODE_W-1:0]  in_code_reg;
    logic                        in_last_reg;

    cfa_pkg::acc_t               acc_reg;
    cfa_pkg::acc_t               acc_next;
    cfa_pkg::acc_t               res_reg;
    logic                        out_valid_reg;

    logic                        advance;
    logic                        step;
    logic [cfa_pkg::SUM_W-1:0]   len_ext;

    // Only a last item needs the output register; others pass straight into the sums.
    assign advance = !in_last_reg || !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign len_ext = {{(cfa_pkg::SUM_W - cfa_pkg::LEN_W){1'b0}}, in_length_reg};

    always_comb begin
        acc_next = acc_reg;
        if (cfa_pkg::eats_query(in_code_reg)) begin
            acc_next.query_sum = acc_reg.query_sum + len_ext;
        end
        if (cfa_pkg::eats_reference(in_code_reg)) begin
            acc_next.reference_sum = acc_reg.reference_sum + len_ext;
        end
        acc_next.total_sum = acc_reg.total_sum + len_ext;
        if (in_code_reg == cfa_pkg::OP_S) begin
            if (!acc_reg.core_seen) begin
                acc_next.leading_clip_sum = acc_reg.leading_clip_sum + len_ext;
            end else begin
                acc_next.trailing_clip_sum = acc_reg.trailing_clip_sum + len_ext;
            end
        end else if (cfa_pkg::is_core(in_code_reg)) begin
            acc_next.core_seen = 1'b1;
            // A clip followed by more alignment is an inner clip.
            if (acc_reg.trailing_clip_sum != '0) begin
                acc_next.trailing_clip_sum = '0;
                acc_next.form_ok           = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= cfa_pkg::ACC_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end

            if (step && in_last_reg) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= cfa_pkg::ACC_RESET;
            end else begin
                if (m_ready) begin
                    out_valid_reg <= 1'b0;
                end
                if (step) begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_length_reg <= s_op_length;
            in_code_reg   <= s_op_code;
            in_last_reg   <= s_last;
        end
        if (step && in_last_reg) begin
            res_reg <= acc_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_query_length     = res_reg.query_sum;
    assign m_reference_length = res_reg.reference_sum;
    assign m_total_length     = res_reg.total_sum;
    assign m_leading_clip     = res_reg.leading_clip_sum;
    assign m_trailing_clip    = res_reg.trailing_clip_sum;
    assign m_well_formed      = res_reg.form_ok;

endmodule

`default_nettype wire

[hw/rtl/cfa_checker.sv]
`default_nettype none

module cfa_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_last,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [cfa_pkg::SUM_W-1:0]   m_query_length,
    input wire logic [cfa_pkg::SUM_W-1:0]   m_total_length,
    input wire logic                        m_well_formed
);

    // A stalled result keeps its values.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_query_length) &&
        $stable(m_total_length) && $stable(m_well_formed))
        else $error("result changed while stalled");

    // A new result follows an accepted transaction that ends a list, via the input and output registers.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last, 2))
        else $error("result without a preceding last transaction");

    // Input backpressure only comes from a waiting result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output register");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind cigar_footprint_accumulator_unit cfa_checker u_cfa_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_last             (s_last),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_query_length     (m_query_length),
    .m_total_length     (m_total_length),
    .m_well_formed      (m_well_formed)
);

`default_nettype wire
